// ===== rtl/core/gbfr_pkg.sv =====
// Shared types and constants for the binary frame receiver.
// Depends on nothing; used by gbfr_ctrl, gbfr_dp and the top level.
`default_nettype none

package gbfr_pkg;

    localparam int BYTE_W             = 8;
    localparam int LEN_OUT_W          = 6;
    localparam int STATUS_W           = 2;
    localparam int CFG_IDX_W          = 8;
    localparam int MAX_PAYLOAD_DEFAULT = 32;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'd181;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'd98;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 8'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LEN_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CK_ERR  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic take_class;
        logic take_id;
        logic take_len_lo;
        logic take_len_hi;
        logic store_byte;
        logic take_check;
        logic emit_len_err;
        logic emit_ck_err;
        logic emit_empty;
        logic drain_start;
        logic drain_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sync1_hit;
        logic sync2_hit;
        logic len_big;
        logic len_zero_in;
        logic len_empty;
        logic count_last;
        logic ck_ok;
        logic out_busy;
        logic out_free;
        logic drain_last;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/gnss_binary_frame_receiver_top.sv =====
// Top level of the binary frame receiver: sequencer plus datapath.
// Depends on gbfr_pkg, gbfr_ctrl and gbfr_dp.
`default_nettype none

// Usage
//   Input channel (in_valid / in_stall / rx_byte): one received byte per item.
//   The receiver hunts the two sync bytes, takes class, id and a little-endian
//   length, buffers the payload and checks the Fletcher-8 sum (A then B).
//   Output channel (out_valid / out_stall / fields): a good frame yields one
//   item per payload byte, last set on the final one; an empty good frame, an
//   oversized length or a checksum mismatch yields a single item with last set.
//   Config port (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 sets
//   the first sync byte, index 1 the second; always ready, new values apply at
//   the next sync comparison.
// Timing
//   A byte is taken whenever in_valid is high and in_stall is low. The
//   single result of a frame appears the cycle after its closing byte.
//   After a good checksum the payload store is read one entry per cycle
//   while out_stall is low or no result is held, with input stalled
//   meanwhile; the store's single read port sets that rate.
//   The closing byte of a frame waits while an earlier result is still held.
// Reset
//   rst_n clears the sequencer to sync hunting and restores the sync bytes.
//   A held result stays put for as long as out_stall is high.

module gnss_binary_frame_receiver_top #(
    parameter int MAX_PAYLOAD = gbfr_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input byte channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [gbfr_pkg::BYTE_W-1:0]         rx_byte,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [gbfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gbfr_pkg::BYTE_W-1:0]         cfg_data,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [gbfr_pkg::BYTE_W-1:0]              msg_class,
    output logic [gbfr_pkg::BYTE_W-1:0]              msg_id,
    output logic [gbfr_pkg::LEN_OUT_W-1:0]           payload_length,
    output logic [gbfr_pkg::BYTE_W-1:0]              payload_byte,
    output logic                                    byte_valid,
    output logic                                    last,
    output logic [gbfr_pkg::STATUS_W-1:0]            status
);

    gbfr_pkg::cmd_t  cmd;
    gbfr_pkg::stat_t sts;

    // register writes never need to wait
    assign cfg_ready = 1'b1;

    gbfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbfr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .sts            (sts),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .msg_class      (msg_class),
        .msg_id         (msg_id),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .byte_valid     (byte_valid),
        .last           (last),
        .status         (status)
    );

endmodule

`default_nettype wire

// ===== rtl/core/gbfr_ctrl.sv =====
// Frame sequencer of the binary frame receiver.
// Depends on gbfr_pkg for the command and status structs.
`default_nettype none

module gbfr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire gbfr_pkg::stat_t sts,
    output gbfr_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_SYNC1,
        S_SYNC2,
        S_CLASS,
        S_ID,
        S_LEN_LO,
        S_LEN_HI,
        S_PAYLOAD,
        S_CK_A,
        S_CK_B,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   acc;

    always_comb
    begin
        case (state_reg)
            S_DRAIN:        in_stall = 1'b1;
            S_LEN_HI,
            S_CK_B:         in_stall = sts.out_busy;
            default:        in_stall = 1'b0;
        endcase
    end

    assign acc = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_SYNC1:
            begin
                if (acc && sts.sync1_hit)
                    state_next = S_SYNC2;
            end
            S_SYNC2:
            begin
                // a mismatching byte is dropped, not rechecked as first sync
                if (acc)
                    state_next = sts.sync2_hit ? S_CLASS : S_SYNC1;
            end
            S_CLASS:
            begin
                if (acc)
                begin
                    cmd.take_class = 1'b1;
                    state_next     = S_ID;
                end
            end
            S_ID:
            begin
                if (acc)
                begin
                    cmd.take_id = 1'b1;
                    state_next  = S_LEN_LO;
                end
            end
            S_LEN_LO:
            begin
                if (acc)
                begin
                    cmd.take_len_lo = 1'b1;
                    state_next      = S_LEN_HI;
                end
            end
            S_LEN_HI:
            begin
                if (acc)
                begin
                    cmd.take_len_hi = 1'b1;
                    if (sts.len_big)
                    begin
                        cmd.emit_len_err = 1'b1;
                        state_next       = S_SYNC1;
                    end
                    else if (sts.len_zero_in)
                        state_next = S_CK_A;
                    else
                        state_next = S_PAYLOAD;
                end
            end
            S_PAYLOAD:
            begin
                if (acc)
                begin
                    cmd.store_byte = 1'b1;
                    if (sts.count_last)
                        state_next = S_CK_A;
                end
            end
            S_CK_A:
            begin
                if (acc)
                begin
                    cmd.take_check = 1'b1;
                    state_next     = S_CK_B;
                end
            end
            S_CK_B:
            begin
                if (acc)
                begin
                    if (!sts.ck_ok)
                    begin
                        cmd.emit_ck_err = 1'b1;
                        state_next      = S_SYNC1;
                    end
                    else if (sts.len_empty)
                    begin
                        cmd.emit_empty = 1'b1;
                        state_next     = S_SYNC1;
                    end
                    else
                    begin
                        cmd.drain_start = 1'b1;
                        state_next      = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (sts.out_free)
                begin
                    cmd.drain_load = 1'b1;
                    if (sts.drain_last)
                        state_next = S_SYNC1;
                end
            end
            default:
            begin
                state_next = S_SYNC1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_SYNC1;
        else
            state_reg <= state_next;
    end

    // no item may enter while the stored payload is being sent out
    a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> in_stall)
        else $error("input accepted during payload drain");

    // a frame error always returns to hunting
    a_error_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_len_err || cmd.emit_ck_err) |=> state_reg == S_SYNC1)
        else $error("frame not closed after error result");

    // the last drained byte returns the sequencer to hunting
    a_drain_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.drain_load && sts.drain_last) |=> state_reg == S_SYNC1)
        else $error("frame not closed after last payload byte");

endmodule

`default_nettype wire

// ===== rtl/core/gbfr_dp.sv =====
// Datapath of the binary frame receiver: sync registers, header capture,
// Fletcher-8 sums, payload store and the result register. Uses gbfr_pkg.
`default_nettype none

module gbfr_dp #(
    parameter int MAX_PAYLOAD = gbfr_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [gbfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gbfr_pkg::BYTE_W-1:0]         cfg_data,
    input  wire logic [gbfr_pkg::BYTE_W-1:0]         rx_byte,
    input  wire gbfr_pkg::cmd_t                     cmd,
    output gbfr_pkg::stat_t                         sts,
    input  wire logic                               out_stall,
    output logic                                    out_valid,
    output logic [gbfr_pkg::BYTE_W-1:0]              msg_class,
    output logic [gbfr_pkg::BYTE_W-1:0]              msg_id,
    output logic [gbfr_pkg::LEN_OUT_W-1:0]           payload_length,
    output logic [gbfr_pkg::BYTE_W-1:0]              payload_byte,
    output logic                                    byte_valid,
    output logic                                    last,
    output logic [gbfr_pkg::STATUS_W-1:0]            status
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int BW    = gbfr_pkg::BYTE_W;

    logic [BW-1:0]    sync_first_reg;
    logic [BW-1:0]    sync_second_reg;
    logic [BW-1:0]    class_reg;
    logic [BW-1:0]    id_reg;
    logic [BW-1:0]    len_lo_reg;
    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_ptr_reg;
    logic [BW-1:0]    sum_a_reg;
    logic [BW-1:0]    sum_b_reg;
    logic [BW-1:0]    check_reg;
    logic [BW-1:0]    store_mem [MAX_PAYLOAD];

    logic             out_valid_reg;
    logic [BW-1:0]    out_class_reg;
    logic [BW-1:0]    out_id_reg;
    logic [gbfr_pkg::LEN_OUT_W-1:0] out_len_reg;
    logic [BW-1:0]    payload_byte_reg;
    logic             byte_valid_reg;
    logic             last_reg;
    logic [gbfr_pkg::STATUS_W-1:0]  status_reg;

    logic [2*BW-1:0]  len_in;
    logic [CNT_W:0]   count_inc;
    logic [CNT_W:0]   rd_inc;
    logic [BW-1:0]    sum_a_next;
    logic [BW-1:0]    sum_b_next;
    logic             add_sum;
    logic             emit_one;

    assign len_in    = {rx_byte, len_lo_reg};
    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign rd_inc    = {1'b0, rd_ptr_reg} + 1'b1;
    assign add_sum   = cmd.take_id || cmd.take_len_lo || cmd.take_len_hi || cmd.store_byte;
    assign emit_one  = cmd.emit_len_err || cmd.emit_ck_err || cmd.emit_empty;

    always_comb
    begin
        if (cmd.take_class)
        begin
            sum_a_next = rx_byte;
            sum_b_next = rx_byte;
        end
        else
        begin
            sum_a_next = sum_a_reg + rx_byte;
            sum_b_next = sum_b_reg + sum_a_next;
        end
    end

    assign sts.sync1_hit   = (rx_byte == sync_first_reg);
    assign sts.sync2_hit   = (rx_byte == sync_second_reg);
    assign sts.len_big     = (len_in > 16'(MAX_PAYLOAD));
    assign sts.len_zero_in = (len_in == '0);
    assign sts.len_empty   = (len_reg == '0);
    assign sts.count_last  = (count_inc >= {1'b0, len_reg});
    assign sts.ck_ok       = (check_reg == sum_a_reg) && (rx_byte == sum_b_reg);
    assign sts.out_busy    = out_valid_reg;
    assign sts.out_free    = !out_valid_reg || !out_stall;
    assign sts.drain_last  = (rd_inc == {1'b0, len_reg});

    // configuration and frame control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= gbfr_pkg::SYNC_FIRST_RESET;
            sync_second_reg <= gbfr_pkg::SYNC_SECOND_RESET;
            class_reg       <= '0;
            id_reg          <= '0;
            len_lo_reg      <= '0;
            len_reg         <= '0;
            count_reg       <= '0;
            rd_ptr_reg      <= '0;
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
            check_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == gbfr_pkg::REG_SYNC_FIRST)
                sync_first_reg <= cfg_data;
            if (cfg_we && cfg_index == gbfr_pkg::REG_SYNC_SECOND)
                sync_second_reg <= cfg_data;
            if (cmd.take_class)
                class_reg <= rx_byte;
            if (cmd.take_id)
                id_reg <= rx_byte;
            if (cmd.take_len_lo)
                len_lo_reg <= rx_byte;
            if (cmd.take_len_hi)
            begin
                len_reg   <= CNT_W'(len_in);
                count_reg <= '0;
            end
            if (cmd.store_byte)
                count_reg <= count_inc[CNT_W-1:0];
            if (cmd.take_class || add_sum)
            begin
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
            end
            if (cmd.take_check)
                check_reg <= rx_byte;
            if (cmd.drain_start)
                rd_ptr_reg <= '0;
            else if (cmd.drain_load)
                rd_ptr_reg <= rd_inc[CNT_W-1:0];
            // hold the result until taken
            if (emit_one || cmd.drain_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload store and result payload (registered memory read)
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte && count_reg < CNT_W'(MAX_PAYLOAD))
            store_mem[count_reg[IDX_W-1:0]] <= rx_byte;
        if (emit_one)
        begin
            out_class_reg    <= class_reg;
            out_id_reg       <= id_reg;
            out_len_reg      <= cmd.emit_ck_err ? gbfr_pkg::LEN_OUT_W'(len_reg) : '0;
            payload_byte_reg <= '0;
            byte_valid_reg   <= 1'b0;
            last_reg         <= 1'b1;
            status_reg       <= cmd.emit_len_err ? gbfr_pkg::ST_LEN_ERR :
                                cmd.emit_ck_err  ? gbfr_pkg::ST_CK_ERR  : gbfr_pkg::ST_OK;
        end
        else if (cmd.drain_load)
        begin
            out_class_reg    <= class_reg;
            out_id_reg       <= id_reg;
            out_len_reg      <= gbfr_pkg::LEN_OUT_W'(len_reg);
            payload_byte_reg <= store_mem[rd_ptr_reg[IDX_W-1:0]];
            byte_valid_reg   <= 1'b1;
            last_reg         <= sts.drain_last;
            status_reg       <= gbfr_pkg::ST_OK;
        end
    end

    assign out_valid      = out_valid_reg;
    assign msg_class      = out_class_reg;
    assign msg_id         = out_id_reg;
    assign payload_length = out_len_reg;
    assign payload_byte   = payload_byte_reg;
    assign byte_valid     = byte_valid_reg;
    assign last           = last_reg;
    assign status         = status_reg;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_one || cmd.drain_load) |-> (!out_valid_reg || !out_stall))
        else $error("result register loaded while still held");

    // data results only carry good status
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && byte_valid_reg) |-> status_reg == gbfr_pkg::ST_OK)
        else $error("payload byte with error status");

    // single results always close the frame
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !byte_valid_reg) |-> last_reg)
        else $error("non-data result without last");

    // the drain never reads past the frame length
    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_load |-> rd_ptr_reg < len_reg)
        else $error("drain read beyond payload length");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for gnss_binary_frame_receiver_top: predicts every result of the
// byte stream in place and checks the result channel against it, field by field.
// Depends on gbfr_pkg and the receiver RTL; nothing else.

module tb;

    localparam int BYTE_W         = gbfr_pkg::BYTE_W;
    localparam int LEN_OUT_W      = gbfr_pkg::LEN_OUT_W;
    localparam int STATUS_W       = gbfr_pkg::STATUS_W;
    localparam int CFG_IDX_W      = gbfr_pkg::CFG_IDX_W;
    localparam int DEPTH          = gbfr_pkg::MAX_PAYLOAD_DEFAULT;
    localparam int IDX_W          = $clog2(DEPTH);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;     // single result lands the cycle after its byte
    localparam int DRAIN_CYCLES   = 40;    // room for a full store to drain
    localparam int LONG_HOLD      = 300;

    // receive sequence of the frame parser, as tracked by the predictor
    typedef enum logic [3:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        GET_CLASS,
        GET_ID,
        GET_LEN_LO,
        GET_LEN_HI,
        GET_PAYLOAD,
        GET_CK_A,
        GET_CK_B
    } rx_phase_t;

    // how a generated frame spoils its checksum
    typedef enum int {
        CK_GOOD,
        CK_BAD_A,
        CK_BAD_B
    } ck_fault_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    cls;
        logic [BYTE_W-1:0]    id;
        logic [LEN_OUT_W-1:0] len;
        logic [BYTE_W-1:0]    data;
        logic                 bv;
        logic                 fin;
        logic [STATUS_W-1:0]  st;
    } frame_result_t;

    // clock, reset and block ports; every input starts at a known value
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte   = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [BYTE_W-1:0]    msg_class;
    logic [BYTE_W-1:0]    msg_id;
    logic [LEN_OUT_W-1:0] payload_length;
    logic [BYTE_W-1:0]    payload_byte;
    logic                 byte_valid;
    logic                 last;
    logic [STATUS_W-1:0]  status;

    // pending bytes for the driver, and results still owed by the block
    logic [BYTE_W-1:0] rx_byte_q[$];
    frame_result_t     frame_result_q[$];
    int                queued_bytes = 0;

    // idling knobs, set per phase by the sequence below
    int   idle_pct        = 0;
    logic long_hold_req   = 1'b0;
    logic long_hold_taken = 1'b0;

    int fail_count   = 0;
    int stuck_cycles = 0;

    // predictor state: a private copy of the sync registers and of the parser
    logic [BYTE_W-1:0] sync1_cfg = gbfr_pkg::SYNC_FIRST_RESET;
    logic [BYTE_W-1:0] sync2_cfg = gbfr_pkg::SYNC_SECOND_RESET;
    rx_phase_t         rx_phase  = HUNT_FIRST;
    logic [BYTE_W-1:0] cls_m     = '0;
    logic [BYTE_W-1:0] id_m      = '0;
    logic [15:0]       len_m     = '0;
    int                count_m   = 0;
    logic [BYTE_W-1:0] sum_a     = '0;
    logic [BYTE_W-1:0] sum_b     = '0;
    logic [BYTE_W-1:0] check_a   = '0;
    logic [BYTE_W-1:0] store_m[DEPTH];

    gnss_binary_frame_receiver_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .msg_class      (msg_class),
        .msg_id         (msg_id),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .byte_valid     (byte_valid),
        .last           (last),
        .status         (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------

    // Fletcher-8: A accumulates the byte, B accumulates A; both wrap at 8 bits
    function void fletcher_add(input logic [BYTE_W-1:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endfunction

    function void owe_result(input logic [LEN_OUT_W-1:0] len, input logic [BYTE_W-1:0] data,
                             input logic bv, input logic fin, input logic [STATUS_W-1:0] st);
        frame_result_t r;
        r.cls  = cls_m;
        r.id   = id_m;
        r.len  = len;
        r.data = data;
        r.bv   = bv;
        r.fin  = fin;
        r.st   = st;
        frame_result_q.push_back(r);
    endfunction

    // Advance the parser by one accepted byte and queue whatever results it causes.
    function void parse_rx_byte(input logic [BYTE_W-1:0] b);
        case (rx_phase)
            HUNT_FIRST:
            begin
                if (b == sync1_cfg)
                    rx_phase = HUNT_SECOND;
            end
            HUNT_SECOND:
            begin
                // a mismatch drops back to hunting; this byte is not retried as sync one
                rx_phase = (b == sync2_cfg) ? GET_CLASS : HUNT_FIRST;
            end
            GET_CLASS:
            begin
                sum_a = '0;
                sum_b = '0;
                cls_m = b;
                fletcher_add(b);
                rx_phase = GET_ID;
            end
            GET_ID:
            begin
                id_m = b;
                fletcher_add(b);
                rx_phase = GET_LEN_LO;
            end
            GET_LEN_LO:
            begin
                len_m = {8'h00, b};
                fletcher_add(b);
                rx_phase = GET_LEN_HI;
            end
            GET_LEN_HI:
            begin
                len_m[15:8] = b;
                fletcher_add(b);
                count_m = 0;
                if (len_m > DEPTH)
                begin
                    // oversized length ends the frame right here
                    owe_result('0, '0, 1'b0, 1'b1, gbfr_pkg::ST_LEN_ERR);
                    rx_phase = HUNT_FIRST;
                end
                else
                begin
                    rx_phase = (len_m == 0) ? GET_CK_A : GET_PAYLOAD;
                end
            end
            GET_PAYLOAD:
            begin
                if (count_m < DEPTH)
                    store_m[IDX_W'(count_m)] = b;
                fletcher_add(b);
                count_m++;
                if (count_m >= len_m)
                    rx_phase = GET_CK_A;
            end
            GET_CK_A:
            begin
                check_a = b;
                rx_phase = GET_CK_B;
            end
            GET_CK_B:
            begin
                if (check_a != sum_a || b != sum_b)
                begin
                    owe_result(len_m[LEN_OUT_W-1:0], '0, 1'b0, 1'b1, gbfr_pkg::ST_CK_ERR);
                end
                else if (len_m == 0)
                begin
                    owe_result('0, '0, 1'b0, 1'b1, gbfr_pkg::ST_OK);
                end
                else
                begin
                    for (int i = 0; i < len_m; i++)
                        owe_result(len_m[LEN_OUT_W-1:0], store_m[IDX_W'(i)], 1'b1,
                                   (i + 1 == len_m), gbfr_pkg::ST_OK);
                end
                rx_phase = HUNT_FIRST;
            end
            default:
            begin
                rx_phase = HUNT_FIRST;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: present the next pending item, hold it while stalled,
    // insert idle bursts when the phase asks for them.
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= '0;
            send_gap <= 0;
        end
        else
        begin
            // predict at the accepting edge from the value the block sampled
            if (in_valid && !in_stall)
                parse_rx_byte(rx_byte);
            // a stalled item stays put; otherwise pick what comes next
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                begin
                    in_valid <= 1'b0;
                    send_gap <= $urandom_range(0, 6);
                end
                else if (rx_byte_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_byte_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted item with the oldest owed result,
    // and drive the receiver's stall in random bursts or one long hold.
    // ------------------------------------------------------------------
    function void check_field(input string name, input int unsigned want,
                              input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    int stall_left = 0;

    always @(posedge clk)
    begin : result_monitor
        frame_result_t want;
        if (!rst_n)
        begin
            out_stall       <= 1'b0;
            stall_left      <= 0;
            long_hold_taken <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (frame_result_q.size() == 0)
                begin
                    $error("result item arrived with nothing owed (class %0d id %0d status %0d)",
                           msg_class, msg_id, status);
                    fail_count++;
                end
                else
                begin
                    want = frame_result_q.pop_front();
                    check_field("msg_class", 32'(want.cls), 32'(msg_class));
                    check_field("msg_id", 32'(want.id), 32'(msg_id));
                    check_field("payload_length", 32'(want.len), 32'(payload_length));
                    check_field("payload_byte", 32'(want.data), 32'(payload_byte));
                    check_field("byte_valid", 32'(want.bv), 32'(byte_valid));
                    check_field("last", 32'(want.fin), 32'(last));
                    check_field("status", 32'(want.st), 32'(status));
                end
            end
            // the long hold lets the block fill up and push back on its input
            if (long_hold_req && !long_hold_taken)
            begin
                long_hold_taken <= 1'b1;
                stall_left      <= LONG_HOLD;
                out_stall       <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left <= $urandom_range(0, 6);
                out_stall  <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which no channel moves anything.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (rst_n);
        while (stuck_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("FAIL gnss_binary_frame_receiver_top");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function void send(input logic [BYTE_W-1:0] b);
        rx_byte_q.push_back(b);
        queued_bytes++;
    endfunction

    // Build one frame with the current sync bytes; payload content is random.
    // Oversized lengths stop after the length bytes, as the block does.
    function void queue_frame(input logic [BYTE_W-1:0] cls, input logic [BYTE_W-1:0] id,
                              input logic [15:0] len, input ck_fault_t fault);
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] bsum;
        logic [BYTE_W-1:0] d;
        a    = '0;
        bsum = '0;
        send(sync1_cfg);
        send(sync2_cfg);
        send(cls);
        a = a + cls;       bsum = bsum + a;
        send(id);
        a = a + id;        bsum = bsum + a;
        send(len[7:0]);
        a = a + len[7:0];  bsum = bsum + a;
        send(len[15:8]);
        a = a + len[15:8]; bsum = bsum + a;
        if (len > DEPTH)
            return;
        for (int i = 0; i < len; i++)
        begin
            d = 8'($urandom_range(0, 255));
            send(d);
            a = a + d;
            bsum = bsum + a;
        end
        // a nonzero xor guarantees the spoiled byte really differs
        if (fault == CK_BAD_A)
            a = a ^ 8'($urandom_range(1, 255));
        if (fault == CK_BAD_B)
            bsum = bsum ^ 8'($urandom_range(1, 255));
        send(a);
        send(bsum);
    endfunction

    // Mostly well-formed frames with random content; some noise, broken sync,
    // oversized lengths and spoiled checksums mixed in.
    task automatic queue_traffic(input int budget);
        int stop;
        int pick;
        logic [15:0] big_len;
        stop = queued_bytes + budget;
        while (queued_bytes < stop)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    send(8'($urandom_range(0, 255)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                case ($urandom_range(0, 3))
                    0:       big_len = 16'(DEPTH + 1);
                    1:       big_len = 16'hFFFF;
                    default: big_len = 16'($urandom_range(DEPTH + 1, 16'hFFFF));
                endcase
                queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            big_len, CK_GOOD);
            end
            else if (pick < 16)
            begin
                queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 6)), (pick < 12) ? CK_BAD_A : CK_BAD_B);
            end
            else if (pick < 20)
            begin
                // broken sync: first byte then anything
                send(sync1_cfg);
                send(8'($urandom_range(0, 255)));
            end
            else if (pick < 24)
            begin
                queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            16'(DEPTH), CK_GOOD);
            end
            else
            begin
                queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 6)), CK_GOOD);
            end
        end
    endtask

    // Write one register; only called while nothing is in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            gbfr_pkg::REG_SYNC_FIRST:  sync1_cfg = val;
            gbfr_pkg::REG_SYNC_SECOND: sync2_cfg = val;
            default:                   ;
        endcase
    endtask

    // Wait until every item went in and every owed result came out,
    // then let a few cycles pass for bytes that cause no result.
    task automatic wait_drained(input int extra);
        do
            @(negedge clk);
        while (rx_byte_q.size() != 0 || in_valid || frame_result_q.size() != 0);
        repeat (extra)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset sync values. Directed part first: a second sync byte that
        // mismatches (and is then not taken as a first sync byte), an empty good
        // frame, an oversized length, a spoiled checksum; class and id at extremes.
        idle_pct = 15;
        send(sync1_cfg);
        send(sync1_cfg);
        send(sync2_cfg);
        queue_frame(8'hFF, 8'h00, 16'd0, CK_GOOD);
        queue_frame(8'h00, 8'hFF, 16'(DEPTH + 1), CK_GOOD);
        queue_frame(8'h5A, 8'hA5, 16'd0, CK_BAD_A);
        queue_traffic(90);
        wait_drained(SETTLE_CYCLES);

        // Sync bytes at opposite extremes.
        write_reg(gbfr_pkg::REG_SYNC_FIRST, 8'h00);
        write_reg(gbfr_pkg::REG_SYNC_SECOND, 8'hFF);
        @(negedge clk);
        idle_pct = 30;
        queue_traffic(90);
        wait_drained(SETTLE_CYCLES);

        // Swapped extremes; no random idling here, but one long hold on the
        // result side while bytes keep coming.
        write_reg(gbfr_pkg::REG_SYNC_FIRST, 8'hFF);
        write_reg(gbfr_pkg::REG_SYNC_SECOND, 8'h00);
        @(negedge clk);
        idle_pct = 0;
        queue_traffic(90);
        long_hold_req = 1'b1;
        wait_drained(SETTLE_CYCLES);

        // Random sync bytes.
        write_reg(gbfr_pkg::REG_SYNC_FIRST, 8'($urandom_range(0, 255)));
        write_reg(gbfr_pkg::REG_SYNC_SECOND, 8'($urandom_range(0, 255)));
        @(negedge clk);
        idle_pct = 20;
        queue_traffic(90);
        wait_drained(SETTLE_CYCLES);

        // Both sync bytes equal.
        begin : same_sync
            logic [BYTE_W-1:0] s;
            s = 8'($urandom_range(0, 255));
            write_reg(gbfr_pkg::REG_SYNC_FIRST, s);
            write_reg(gbfr_pkg::REG_SYNC_SECOND, s);
        end
        @(negedge clk);
        idle_pct = 10;
        queue_traffic(60);
        wait_drained(SETTLE_CYCLES);

        // Back to reset values, full speed on both sides to the end.
        write_reg(gbfr_pkg::REG_SYNC_FIRST, gbfr_pkg::SYNC_FIRST_RESET);
        write_reg(gbfr_pkg::REG_SYNC_SECOND, gbfr_pkg::SYNC_SECOND_RESET);
        @(negedge clk);
        idle_pct = 0;
        queue_traffic(60);
        wait_drained(DRAIN_CYCLES);

        if (frame_result_q.size() != 0)
        begin
            $error("%0d result items never arrived", frame_result_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS gnss_binary_frame_receiver_top");
        else
            $display("FAIL gnss_binary_frame_receiver_top");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/gbfr_pkg.sv
rtl/core/gbfr_ctrl.sv
rtl/core/gbfr_dp.sv
rtl/core/gnss_binary_frame_receiver_top.sv
tb/sv/tb.sv
